// File: hw/rtl/fast_inverse_square_root_top_macros.svh
// assertion macros used by the checker file
`ifndef FAST_INVERSE_SQUARE_ROOT_TOP_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define FRSQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frsq check failed");

// next-cycle implication, masked during reset
`define FRSQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frsq check failed");

// next-cycle implication that also holds across reset
`define FRSQ_ASSERT_NXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("frsq reset check failed");

`endif

// File: hw/rtl/frsq_pkg.sv
// package: lane type, cell op codes and single-precision arithmetic
package frsq_pkg;

    localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
    localparam logic [31:0] CANON_QNAN  = 32'h7fc00000;
    localparam logic [31:0] FP_HALF     = 32'h3f000000;
    localparam logic [31:0] FP_ONE_P5   = 32'h3fc00000;
    localparam int          NUM_CELLS   = 12;

    typedef logic [1:0] t_op;
    localparam t_op OP_MUL_XY = 2'd0;  // w = x2 * y
    localparam t_op OP_MUL_WY = 2'd1;  // w = w * y
    localparam t_op OP_SUB    = 2'd2;  // w = 1.5 - w
    localparam t_op OP_MUL_YW = 2'd3;  // y = y * w

    typedef struct packed {
        logic [31:0] x2;
        logic [31:0] y;
        logic [31:0] w;
    } t_lane;

    function automatic t_op cell_op(input int idx);
        logic [1:0] k;
        k = idx[1:0];
        return t_op'(k);
    endfunction

    function automatic logic [5:0] lzc51(input logic [50:0] v);
        logic [5:0] n;
        n = 6'd51;
        for (int i = 0; i < 51; i++) begin
            if (v[i]) begin
                n = 6'(50 - i);
            end
        end
        return n;
    endfunction

    // n has its leading one at bit 50, e is the biased exponent of that bit
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [50:0] n);
        logic [11:0] sh;
        logic [50:0] m;
        logic [50:0] mask;
        logic        lost;
        logic [7:0]  ef;
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic        up;
        logic [30:0] r;
        if (e >= 12'sd255) begin
            return {s, 8'hff, 23'd0};
        end
        if (e < 12'sd1) begin
            sh = 12'(12'sd1 - e);
            if (sh >= 12'd51) begin
                m    = '0;
                lost = |n;
            end else begin
                mask = ~({51{1'b1}} << sh[5:0]);
                m    = n >> sh[5:0];
                lost = |(n & mask);
            end
            ef = 8'd0;
        end else begin
            m    = n;
            lost = 1'b0;
            ef   = 8'(e - 12'sd1);
        end
        mant = m[50:27];
        g    = m[26];
        st   = (|m[25:0]) | lost;
        up   = g & (st | mant[0]);
        r    = {ef, 23'd0} + {7'd0, mant} + {30'd0, up};
        return {s, r};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        an, bn, ai, bi, az, bz;
        logic [23:0] ma, mb;
        logic [7:0]  xa, xb;
        logic [47:0] p;
        logic [5:0]  lz;
        logic [50:0] n;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        an = (a[30:23] == 8'hff) && (a[22:0] != '0);
        bn = (b[30:23] == 8'hff) && (b[22:0] != '0);
        ai = (a[30:23] == 8'hff) && (a[22:0] == '0);
        bi = (b[30:23] == 8'hff) && (b[22:0] == '0);
        az = (a[30:0] == '0);
        bz = (b[30:0] == '0);
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        xb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        if (an || bn || (ai && bz) || (bi && az)) begin
            return CANON_QNAN;
        end
        if (ai || bi) begin
            return {s, 8'hff, 23'd0};
        end
        if (az || bz) begin
            return {s, 31'd0};
        end
        p  = ma * mb;
        lz = lzc51({p, 3'b000});
        n  = {p, 3'b000} << lz;
        e  = 12'($signed({4'd0, xa})) + 12'($signed({4'd0, xb})) - 12'sd126
             - 12'($signed({6'd0, lz}));
        return round_pack(s, e, n);
    endfunction

    // a - b
    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] c;
        logic        an, cn, ai, ci, az, cz;
        logic [23:0] ma, mc, mbig, msml;
        logic [7:0]  xa, xc, xbig, xsml, d;
        logic        sbig, swap;
        logic [50:0] aa, bf, bb, mask, sum, n;
        logic        st;
        logic [5:0]  lz;
        logic signed [11:0] e;
        c  = {~b[31], b[30:0]};
        an = (a[30:23] == 8'hff) && (a[22:0] != '0);
        cn = (c[30:23] == 8'hff) && (c[22:0] != '0);
        ai = (a[30:23] == 8'hff) && (a[22:0] == '0);
        ci = (c[30:23] == 8'hff) && (c[22:0] == '0);
        az = (a[30:0] == '0);
        cz = (c[30:0] == '0);
        ma = {a[30:23] != 8'd0, a[22:0]};
        mc = {c[30:23] != 8'd0, c[22:0]};
        xa = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        xc = (c[30:23] == 8'd0) ? 8'd1 : c[30:23];
        if (an || cn || (ai && ci && (a[31] != c[31]))) begin
            return CANON_QNAN;
        end
        if (ai) begin
            return a;
        end
        if (ci) begin
            return c;
        end
        if (az && cz) begin
            return {a[31] & c[31], 31'd0};
        end
        swap = (xa < xc) || ((xa == xc) && (ma < mc));
        mbig = swap ? mc : ma;
        msml = swap ? ma : mc;
        xbig = swap ? xc : xa;
        xsml = swap ? xa : xc;
        sbig = swap ? c[31] : a[31];
        d    = xbig - xsml;
        aa   = {1'b0, mbig, 26'd0};
        bf   = {1'b0, msml, 26'd0};
        if (d >= 8'd51) begin
            bb = '0;
            st = |msml;
        end else begin
            mask = ~({51{1'b1}} << d[5:0]);
            bb   = bf >> d[5:0];
            st   = |(bf & mask);
        end
        bb  = bb | {50'd0, st};
        sum = (a[31] == c[31]) ? (aa + bb) : (aa - bb);
        if (sum == '0) begin
            return 32'd0;
        end
        lz = lzc51(sum);
        n  = sum << lz;
        e  = 12'($signed({4'd0, xbig})) + 12'sd1 - 12'($signed({6'd0, lz}));
        return round_pack(sbig, e, n);
    endfunction

endpackage

// File: hw/rtl/frsq_if.sv
// stream interfaces for the input value and the result
interface frsq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface frsq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rsqrt_bits;
    modport source (output valid, output rsqrt_bits, input ready);
    modport sink   (input valid, input rsqrt_bits, output ready);
endinterface

// File: hw/rtl/frsq_seed.sv
// first stage: halves the input and forms the magic-constant guess
module frsq_seed (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_value_bits,
    output logic                 o_ready,
    output logic                 o_valid,
    output frsq_pkg::t_lane      o_lane,
    input  logic                 i_ready
);
    logic            r_valid;
    frsq_pkg::t_lane r_lane;
    frsq_pkg::t_lane n_lane;
    logic [31:0]     w_half;

    assign o_ready = !r_valid || i_ready;
    assign w_half  = {i_value_bits[31], i_value_bits[31:1]};

    always_comb begin
        n_lane.x2 = frsq_pkg::fp_mul(i_value_bits, frsq_pkg::FP_HALF);
        n_lane.y  = frsq_pkg::MAGIC_GUESS - w_half;
        n_lane.w  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
endmodule

// File: hw/rtl/frsq_cell.sv
// one newton cell: a single float operation on the lane, registered
module frsq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  frsq_pkg::t_op        i_op,
    input  logic                 i_valid,
    input  frsq_pkg::t_lane      i_lane,
    output logic                 o_ready,
    output logic                 o_valid,
    output frsq_pkg::t_lane      o_lane,
    input  logic                 i_ready
);
    logic            r_valid;
    frsq_pkg::t_lane r_lane;
    frsq_pkg::t_lane n_lane;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_lane = i_lane;
        unique case (i_op)
            frsq_pkg::OP_MUL_XY: n_lane.w = frsq_pkg::fp_mul(i_lane.x2, i_lane.y);
            frsq_pkg::OP_MUL_WY: n_lane.w = frsq_pkg::fp_mul(i_lane.w, i_lane.y);
            frsq_pkg::OP_SUB:    n_lane.w = frsq_pkg::fp_sub(frsq_pkg::FP_ONE_P5, i_lane.w);
            frsq_pkg::OP_MUL_YW: n_lane.y = frsq_pkg::fp_mul(i_lane.y, i_lane.w);
            default:             n_lane = i_lane;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
endmodule

// File: hw/rtl/fast_inverse_square_root_top.sv
// Approximate reciprocal square root of a single-precision value (raw bits in, raw bits
// out): magic-constant guess, then three Newton steps in single precision with round to
// nearest even and subnormals kept; any NaN result comes out as 0x7fc00000. One value
// is taken per clock while no stall reaches the input; a result passes through one seed
// stage and a row of twelve cells, each doing one float multiply or subtract. The row
// stalls stage by stage, so bubbles are squeezed out while the output is held back.
module fast_inverse_square_root_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frsq_in_if.sink     i_value,
    frsq_out_if.source  o_rsqrt
);
    logic            w_valid [frsq_pkg::NUM_CELLS+1];
    logic            w_ready [frsq_pkg::NUM_CELLS+1];
    frsq_pkg::t_lane w_lane  [frsq_pkg::NUM_CELLS+1];
    logic [31:0]     w_y;

    frsq_seed u_seed (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_value.valid),
        .i_value_bits (i_value.value_bits),
        .o_ready      (i_value.ready),
        .o_valid      (w_valid[0]),
        .o_lane       (w_lane[0]),
        .i_ready      (w_ready[0])
    );

    for (genvar g = 0; g < frsq_pkg::NUM_CELLS; g++) begin : g_cell
        frsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (frsq_pkg::cell_op(g)),
            .i_valid (w_valid[g]),
            .i_lane  (w_lane[g]),
            .o_ready (w_ready[g]),
            .o_valid (w_valid[g+1]),
            .o_lane  (w_lane[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    assign w_ready[frsq_pkg::NUM_CELLS] = o_rsqrt.ready;
    assign w_y = w_lane[frsq_pkg::NUM_CELLS].y;

    // any nan leaves as the canonical quiet nan
    assign o_rsqrt.valid      = w_valid[frsq_pkg::NUM_CELLS];
    assign o_rsqrt.rsqrt_bits = ((w_y[30:23] == 8'hff) && (w_y[22:0] != '0))
                                ? frsq_pkg::CANON_QNAN : w_y;
endmodule

// File: hw/rtl/frsq_checker.sv
// port-level checks on the top level, attached by bind
`include "fast_inverse_square_root_top_macros.svh"

module frsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_bits
);
    `FRSQ_ASSERT_NXT_RST(a_reset_empty, !i_rst_n, !i_out_valid)
    `FRSQ_ASSERT_IMP(a_empty_takes, !i_out_valid, i_in_ready)
    `FRSQ_ASSERT_IMP(a_drain_takes, i_out_ready, i_in_ready)
    `FRSQ_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_bits))
endmodule

bind fast_inverse_square_root_top frsq_checker u_frsq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_value.ready),
    .i_out_valid (o_rsqrt.valid),
    .i_out_ready (o_rsqrt.ready),
    .i_out_bits  (o_rsqrt.rsqrt_bits)
);
